// File: sv/fpt_pkg.sv
package fpt_pkg;

  localparam int IDX_W   = 9;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 64;
  localparam int FADDR_W = 40;   // frame address, bits 51:12

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NOMAP     = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_EVAL, S_CLR, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO, RES_VA, RES_PHYS, RES_EXH, RES_NOMAP
  } res_kind_t;

  typedef struct packed {
    logic      take;      // request side ready
    logic      rd;        // read entry of current level
    logic      alloc;     // link next free frame into current entry
    logic      follow;    // descend through a valid link
    logic      clr_wr;    // zero one entry of the current frame
    logic      step;      // descend after a clear
    logic      leaf_wr;   // write leaf entry
    logic      set_res;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] op;
    logic       last;
    logic       present;
    logic       link_ok;
    logic       pool_full;
    logic       clr_last;
    logic       out_free;
  } stat_t;

endpackage

// File: sv/fpt_req_if.sv
interface fpt_req_if;
  import fpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [VA_W-1:0]    virt_addr;
  logic [PA_W-1:0]    phys_addr;
  logic [ENTRY_W-1:0] page_flags;
  modport source (output valid, opcode, virt_addr, phys_addr, page_flags, input ready);
  modport sink   (input valid, opcode, virt_addr, phys_addr, page_flags, output ready);
endinterface

// File: sv/fpt_rsp_if.sv
interface fpt_rsp_if;
  import fpt_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [PA_W-1:0] result_addr;
  modport source (output valid, status, result_addr, input ready);
  modport sink   (input valid, status, result_addr, output ready);
endinterface

// File: sv/fpt_ram.sv
module fpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: sv/fpt_ctrl.sv
module fpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  fpt_pkg::stat_t st,
  output fpt_pkg::cmd_t  cmd
);
  import fpt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (st.clr_last) state_next = S_IDLE;
      S_IDLE: if (st.in_valid) state_next = S_RD;
      S_RD:   state_next = S_EVAL;
      S_EVAL: begin
        if (st.op == OP_MAP && !st.last && !st.present && !st.pool_full) begin
          state_next = S_CLR;
        end else if (st.op != OP_MAP && st.op != OP_UNMAP && st.op != OP_XLATE) begin
          state_next = S_DONE;
        end else if (!st.last && st.link_ok) begin
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLR:  if (st.clr_last) state_next = S_RD;
      S_DONE: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_kind = RES_ZERO;
    case (state)
      S_INIT: cmd.clr_wr = 1'b1;
      S_IDLE: cmd.take = 1'b1;
      S_RD:   cmd.rd = 1'b1;
      S_EVAL: begin
        if (st.op != OP_MAP && st.op != OP_UNMAP && st.op != OP_XLATE) begin
          cmd.set_res = 1'b1;
        end else if (!st.last) begin
          if (st.op == OP_MAP && !st.present) begin
            if (st.pool_full) begin
              cmd.set_res  = 1'b1;
              cmd.res_kind = RES_EXH;
            end else begin
              cmd.alloc = 1'b1;
            end
          end else if (st.link_ok) begin
            cmd.follow = 1'b1;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_kind = (st.op == OP_MAP) ? RES_EXH : RES_NOMAP;
          end
        end else begin
          cmd.set_res = 1'b1;
          case (st.op)
            OP_MAP: begin
              cmd.leaf_wr  = 1'b1;
              cmd.res_kind = RES_VA;
            end
            OP_UNMAP: begin
              cmd.leaf_wr  = 1'b1;
              cmd.res_kind = st.present ? RES_ZERO : RES_NOMAP;
            end
            OP_XLATE: cmd.res_kind = st.present ? RES_PHYS : RES_NOMAP;
            default:  cmd.res_kind = RES_ZERO;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.step   = st.clr_last;
      end
      S_DONE: cmd.out_load = st.out_free;
      default: ;
    endcase
  end
endmodule

// File: sv/fpt_dpath.sv
module fpt_dpath #(
  parameter int POOL_FRAMES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [fpt_pkg::PA_W-1:0] cfg_data,
  fpt_req_if.sink                 req,
  fpt_rsp_if.source               rsp,
  input  fpt_pkg::cmd_t           cmd,
  output fpt_pkg::stat_t          st
);
  import fpt_pkg::*;

  localparam int FRW = $clog2(POOL_FRAMES);
  localparam int NFW = $clog2(POOL_FRAMES + 1);
  localparam int AW  = FRW + IDX_W;
  localparam int DEPTH = POOL_FRAMES * 512;

  logic [PA_W-1:0]    pool_base;
  logic [1:0]         op;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    pa;
  logic [ENTRY_W-1:0] flags;
  logic [FRW-1:0]     frame;
  logic [1:0]         level;
  logic [NFW-1:0]     next_free;
  logic [IDX_W-1:0]   clr_cnt;
  logic [1:0]         res_status;
  logic [PA_W-1:0]    res_addr;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [PA_W-1:0]    out_addr;

  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   idx;
  logic [FADDR_W-1:0] rel;
  logic [FADDR_W-1:0] nf_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               accept;

  always_comb begin
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  assign rel     = rdata[51:12] - pool_base[51:12];
  assign nf_addr = pool_base[51:12] + FADDR_W'(next_free);
  assign accept  = cmd.take && req.valid;

  always_comb begin
    we    = cmd.clr_wr || cmd.alloc || cmd.leaf_wr;
    waddr = cmd.clr_wr ? {frame, clr_cnt} : {frame, idx};
    if (cmd.alloc) begin
      wdata = {12'd0, nf_addr, 10'd0, 2'b11};
    end else if (cmd.leaf_wr && op == OP_MAP) begin
      wdata = {12'd0, pa} | flags | ENTRY_W'(1);
    end else begin
      wdata = '0;
    end
  end

  fpt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr ({frame, idx}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      frame     <= '0;
      level     <= '0;
      next_free <= NFW'(1);
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) pool_base <= cfg_data;
      if (accept) begin
        frame <= '0;
        level <= '0;
      end
      if (cmd.alloc) begin
        frame     <= next_free[FRW-1:0];
        next_free <= next_free + NFW'(1);
      end
      if (cmd.follow) begin
        frame <= rel[FRW-1:0];
        level <= level + 2'd1;
      end
      if (cmd.step) level <= level + 2'd1;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + IDX_W'(1);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.opcode;
      va    <= req.virt_addr;
      pa    <= req.phys_addr;
      flags <= req.page_flags;
    end
    if (cmd.set_res) begin
      case (cmd.res_kind)
        RES_VA: begin
          res_status <= ST_OK;
          res_addr   <= PA_W'(va);
        end
        RES_PHYS: begin
          res_status <= ST_OK;
          res_addr   <= {rdata[51:12], va[11:0]};
        end
        RES_EXH: begin
          res_status <= ST_EXHAUSTED;
          res_addr   <= '0;
        end
        RES_NOMAP: begin
          res_status <= ST_NOMAP;
          res_addr   <= '0;
        end
        default: begin
          res_status <= ST_OK;
          res_addr   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  assign req.ready       = cmd.take;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.result_addr = out_addr;

  assign st.in_valid  = req.valid;
  assign st.op        = op;
  assign st.last      = (level == LVL_LEAF);
  assign st.present   = rdata[0];
  assign st.link_ok   = rdata[0] && (rel < FADDR_W'(next_free));
  assign st.pool_full = (next_free >= NFW'(POOL_FRAMES));
  assign st.clr_last  = (clr_cnt == '1);
  assign st.out_free  = !out_valid || rsp.ready;
endmodule

// File: sv/four_level_page_table_manager.sv
// Each table level is read, then evaluated; a map that allocates a table also clears it
// before descending into it (one entry cleared a cycle).
// Throughput: one request at a time; a new one is taken while the last reply waits.
// Reset (rst, synchronous): clearing pass over the root table, no request
// taken meanwhile; next free frame 1, pool base 0.
module four_level_page_table_manager #(
  parameter int POOL_FRAMES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  fpt_req_if.sink                  req,
  fpt_rsp_if.source                rsp,
  input  logic                     cfg_we,
  input  logic [fpt_pkg::PA_W-1:0] cfg_data
);
  import fpt_pkg::*;

  // controller sequences the walk; datapath holds the table RAM, walk
  // registers, bump allocator and the reply register
  cmd_t  cmd;
  stat_t st;

  fpt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  fpt_dpath #(.POOL_FRAMES(POOL_FRAMES)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .st       (st)
  );
endmodule

// File: sv/fpt_checker.sv
module fpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic [51:0] result_addr
);
  import fpt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("reply dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while walk busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_EXHAUSTED || status == ST_NOMAP))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> result_addr == '0)
    else $error("failed reply carries an address");
endmodule

bind four_level_page_table_manager fpt_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .result_addr (rsp.result_addr)
);
